// ===== rtl/core/bma_pkg.sv =====
package bma_pkg;

  // Pool geometry
  localparam int unsigned TOTAL_UNITS = 1024;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned AMT_W       = 11;
  localparam int unsigned NODE_COUNT  = 2 * TOTAL_UNITS - 1;
  localparam int unsigned NODE_W      = 11;
  localparam int unsigned DEPTH_W     = 4;
  localparam int unsigned LEAF_DEPTH  = 10;

  // Node states
  localparam logic [1:0] NS_ABSENT = 2'd0;
  localparam logic [1:0] NS_FREE   = 2'd1;
  localparam logic [1:0] NS_SPLIT  = 2'd2;
  localparam logic [1:0] NS_ALLOC  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_FREED     = 2'd2;
  localparam logic [1:0] ST_NO_MATCH  = 2'd3;

  // Request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Cursor moves
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_LOAD  = 3'd1;
  localparam logic [2:0] ACT_LEFT  = 3'd2;
  localparam logic [2:0] ACT_RIGHT = 3'd3;
  localparam logic [2:0] ACT_SIB   = 3'd4;
  localparam logic [2:0] ACT_UP    = 3'd5;

  // Write targets relative to the cursor
  localparam logic [1:0] WS_SELF = 2'd0;
  localparam logic [1:0] WS_LO   = 2'd1;
  localparam logic [1:0] WS_HI   = 2'd2;
  localparam logic [1:0] WS_SIB  = 2'd3;

  typedef struct packed {
    logic       clr_step;
    logic       rd_en;
    logic       rd_sib;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic [1:0] wr_val;
    logic [2:0] act;
    logic       res_set;
    logic [1:0] res_status;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] node;
    logic       is_leaf;
    logic       at_root;
    logic       is_left;
    logic       fits;
    logic       can_split;
    logic       match;
    logic       go_hi;
    logic       clr_done;
  } stat_t;

endpackage

// ===== rtl/core/bma_ram.sv =====
module bma_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bma_dp.sv =====
module bma_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bma_pkg::cmd_t        cmd_i,
  output bma_pkg::stat_t       stat_o,
  input  logic                 op_i,
  input  logic [10:0]          amount_i,
  input  logic [9:0]           block_start_i,
  output logic [9:0]           start_address_o,
  output logic [1:0]           status_o
);
  import bma_pkg::*;

  logic [NODE_W-1:0]  idx_q, idx_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [ADDR_W-1:0]  start_q, start_d;
  logic [AMT_W-1:0]   req_q, amt_q;
  logic [ADDR_W-1:0]  bs_q;
  logic [NODE_W-1:0]  clr_q;
  logic [ADDR_W-1:0]  res_start_q, out_start_q;
  logic [1:0]         res_status_q, out_status_q;
  logic [AMT_W-1:0]   size, half;
  logic [AMT_W-1:0]   mid;
  logic [NODE_W-1:0]  sib_idx, waddr, raddr;
  logic [1:0]         wdata, rdata;
  logic               we;

  assign size    = AMT_W'(TOTAL_UNITS) >> depth_q;
  assign half    = size >> 1;
  assign mid     = AMT_W'(start_q) + half;
  assign sib_idx = idx_q[0] ? idx_q + NODE_W'(1) : idx_q - NODE_W'(1);

  // Node store: clearing pass owns the write port until it is done.
  always_comb begin
    we    = cmd_i.wr_en | cmd_i.clr_step;
    wdata = cmd_i.wr_val;
    case (cmd_i.wr_sel)
      WS_SELF: waddr = idx_q;
      WS_LO:   waddr = {idx_q[NODE_W-2:0], 1'b1};
      WS_HI:   waddr = {idx_q[NODE_W-2:0], 1'b0} + NODE_W'(2);
      WS_SIB:  waddr = sib_idx;
      default: waddr = idx_q;
    endcase
    if (cmd_i.clr_step) begin
      waddr = clr_q;
      wdata = (clr_q == '0) ? NS_FREE : NS_ABSENT;
    end
    raddr = cmd_i.rd_sib ? sib_idx : idx_q;
  end

  bma_ram #(
    .WIDTH(2),
    .DEPTH(2 ** NODE_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Cursor moves through the implicit tree.
  always_comb begin
    idx_d   = idx_q;
    depth_d = depth_q;
    start_d = start_q;
    case (cmd_i.act)
      ACT_LOAD: begin
        idx_d   = '0;
        depth_d = '0;
        start_d = '0;
      end
      ACT_LEFT: begin
        idx_d   = {idx_q[NODE_W-2:0], 1'b1};
        depth_d = depth_q + DEPTH_W'(1);
      end
      ACT_RIGHT: begin
        idx_d   = {idx_q[NODE_W-2:0], 1'b0} + NODE_W'(2);
        depth_d = depth_q + DEPTH_W'(1);
        start_d = mid[ADDR_W-1:0];
      end
      ACT_SIB: begin
        idx_d   = idx_q + NODE_W'(1);
        start_d = start_q + size[ADDR_W-1:0];
      end
      ACT_UP: begin
        idx_d   = (idx_q - NODE_W'(1)) >> 1;
        depth_d = depth_q - DEPTH_W'(1);
        if (!idx_q[0]) begin
          start_d = start_q - size[ADDR_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + NODE_W'(1);
    end
  end

  // Cursor and request registers.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    depth_q <= depth_d;
    start_q <= start_d;
    if (cmd_i.act == ACT_LOAD) begin
      amt_q <= amount_i;
      bs_q  <= block_start_i;
      req_q <= (op_i == OP_ALLOC && amount_i == '0) ? AMT_W'(1) : amount_i;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_start_q  <= (cmd_i.res_status == ST_ALLOCATED) ? start_q : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_start_q  <= res_start_q;
    end
  end

  assign stat_o.node      = rdata;
  assign stat_o.is_leaf   = (depth_q == DEPTH_W'(LEAF_DEPTH));
  assign stat_o.at_root   = (idx_q == '0);
  assign stat_o.is_left   = idx_q[0];
  assign stat_o.fits      = (size >= req_q);
  assign stat_o.can_split = (depth_q != DEPTH_W'(LEAF_DEPTH)) && (half >= req_q);
  assign stat_o.match     = (start_q == bs_q) && (size == amt_q);
  assign stat_o.go_hi     = (AMT_W'(bs_q) >= mid);
  assign stat_o.clr_done  = (clr_q == NODE_W'(NODE_COUNT));

  assign start_address_o = out_start_q;
  assign status_o        = out_status_q;

endmodule

// ===== rtl/core/bma_ctrl.sv =====
module bma_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  input  logic           s_op_i,
  output logic           s_ready_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  input  bma_pkg::stat_t stat_i,
  output bma_pkg::cmd_t  cmd_o
);
  import bma_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ARD  = 4'd2;
  localparam logic [3:0] S_AEV  = 4'd3;
  localparam logic [3:0] S_AS1  = 4'd4;
  localparam logic [3:0] S_AS2  = 4'd5;
  localparam logic [3:0] S_ABK  = 4'd6;
  localparam logic [3:0] S_FRD  = 4'd7;
  localparam logic [3:0] S_FEV  = 4'd8;
  localparam logic [3:0] S_MRD  = 4'd9;
  localparam logic [3:0] S_MEV  = 4'd10;
  localparam logic [3:0] S_MW2  = 4'd11;
  localparam logic [3:0] S_MW3  = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0] state_q, state_d;
  logic       mvalid_q, mvalid_d;
  logic       out_free;

  assign out_free  = !mvalid_q || m_ready_i;
  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = mvalid_q;

  // Sequencer over the node store.
  always_comb begin
    state_d  = state_q;
    mvalid_d = mvalid_q && !m_ready_i;
    cmd_o    = '0;
    case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.act = ACT_LOAD;
          state_d   = (s_op_i == OP_FREE) ? S_FRD : S_ARD;
        end
      end
      S_ARD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_AEV;
      end
      S_AEV: begin
        if (stat_i.node == NS_SPLIT && !stat_i.is_leaf) begin
          cmd_o.act = ACT_LEFT;
          state_d   = S_ARD;
        end else if (stat_i.node == NS_FREE && stat_i.fits) begin
          cmd_o.wr_en = 1'b1;
          cmd_o.wr_sel = WS_SELF;
          if (stat_i.can_split) begin
            cmd_o.wr_val = NS_SPLIT;
            state_d      = S_AS1;
          end else begin
            cmd_o.wr_val     = NS_ALLOC;
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_ALLOCATED;
            state_d          = S_FIN;
          end
        end else begin
          state_d = S_ABK;
        end
      end
      S_AS1: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WS_LO;
        cmd_o.wr_val = NS_FREE;
        state_d      = S_AS2;
      end
      S_AS2: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WS_HI;
        cmd_o.wr_val = NS_FREE;
        cmd_o.act    = ACT_LEFT;
        state_d      = S_ARD;
      end
      // Backtrack: a left child hands over to its sibling, a right child climbs.
      S_ABK: begin
        if (stat_i.at_root) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_NO_SPACE;
          state_d          = S_FIN;
        end else if (stat_i.is_left) begin
          cmd_o.act = ACT_SIB;
          state_d   = S_ARD;
        end else begin
          cmd_o.act = ACT_UP;
        end
      end
      S_FRD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_FEV;
      end
      S_FEV: begin
        if (stat_i.node == NS_ABSENT) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_NO_MATCH;
          state_d          = S_FIN;
        end else if (stat_i.match) begin
          if (stat_i.node == NS_ALLOC) begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WS_SELF;
            cmd_o.wr_val = NS_FREE;
            state_d      = S_MRD;
          end else begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_NO_MATCH;
            state_d          = S_FIN;
          end
        end else if (stat_i.node != NS_SPLIT || stat_i.is_leaf) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_NO_MATCH;
          state_d          = S_FIN;
        end else begin
          cmd_o.act = stat_i.go_hi ? ACT_RIGHT : ACT_LEFT;
          state_d   = S_FRD;
        end
      end
      // Merge: the cursor node is free; fold it with a free buddy and climb.
      S_MRD: begin
        if (stat_i.at_root) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_FREED;
          state_d          = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sib = 1'b1;
          state_d      = S_MEV;
        end
      end
      S_MEV: begin
        if (stat_i.node == NS_FREE) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WS_SELF;
          cmd_o.wr_val = NS_ABSENT;
          state_d      = S_MW2;
        end else begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_FREED;
          state_d          = S_FIN;
        end
      end
      S_MW2: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WS_SIB;
        cmd_o.wr_val = NS_ABSENT;
        cmd_o.act    = ACT_UP;
        state_d      = S_MW3;
      end
      S_MW3: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WS_SELF;
        cmd_o.wr_val = NS_FREE;
        state_d      = S_MRD;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          mvalid_d       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
    end
  end

endmodule

// ===== rtl/core/buddy_memory_allocator_core.sv =====
// Channel   Direction  tdata                              tuser
// s_axis    in         amount[10:0], block_start[20:11]   op
// m_axis    out        start_address[9:0]                 status
//
// An allocate reads each tree node it visits, steps to a sibling or climbs a level
// on backtrack, and on a split marks the node split and both of its children free.
// It is slowest on a failed walk over a fully split tree, as the node store has a
// single read port. A free walks down to the named block, then merges free buddies
// while it climbs. After reset a clearing pass over the node store runs before the
// first input transfer is taken. One request is worked at a time; the result
// register lets the next request start while the previous result waits.
module buddy_memory_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // amount[10:0], block_start[20:11], zero[23:21]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // start_address[9:0], zero[15:10]
  output logic [1:0]  m_axis_tuser    // status
);
  import bma_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [9:0] start_address;

  bma_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_op_i   (s_axis_tuser),
    .s_ready_o(s_axis_tready),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  bma_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (s_axis_tuser),
    .amount_i       (s_axis_tdata[10:0]),
    .block_start_i  (s_axis_tdata[20:11]),
    .start_address_o(start_address),
    .status_o       (m_axis_tuser)
  );

  assign m_axis_tdata = {6'd0, start_address};

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bma_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned WATCH_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 6000;

  typedef struct {
    logic              op;
    logic [AMT_W-1:0]  amount;
    logic [ADDR_W-1:0] block_start;
    logic [ADDR_W-1:0] exp_addr;
    logic [1:0]        exp_status;
  } request_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
  } grant_t;

  typedef struct {
    int unsigned start;
    int unsigned size;
  } block_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Shadow copy of the node tree.
  logic [1:0] tree_q [NODE_COUNT];

  request_t    req_pending [$];
  grant_t      grant_expected [$];
  block_t      live_blocks [$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  bit          hold_req;
  bit          in_transfer;
  int unsigned fail_count;
  int unsigned quiet_cycles;

  buddy_memory_allocator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Depth-first search for the first free node that fits; split and allocate.
  function automatic bit carve_block(int unsigned idx, int unsigned start,
                                     int unsigned size, int unsigned want,
                                     output int unsigned where);
    int unsigned lo;
    int unsigned hi;
    int unsigned half;
    lo = 2 * idx + 1;
    hi = lo + 1;
    half = size / 2;
    where = 0;
    if (idx >= NODE_COUNT) return 1'b0;
    if (tree_q[idx] == NS_SPLIT) begin
      if (hi >= NODE_COUNT) return 1'b0;
      if (carve_block(lo, start, half, want, where)) return 1'b1;
      return carve_block(hi, start + half, half, want, where);
    end
    if (tree_q[idx] != NS_FREE || size < want) return 1'b0;
    if (size >= 2 && half >= want && hi < NODE_COUNT) begin
      tree_q[idx] = NS_SPLIT;
      tree_q[lo] = NS_FREE;
      tree_q[hi] = NS_FREE;
      return carve_block(lo, start, half, want, where);
    end
    tree_q[idx] = NS_ALLOC;
    where = start;
    return 1'b1;
  endfunction

  // Release a named block and merge free buddies on the way back up.
  function automatic logic [1:0] release_block(int unsigned idx, int unsigned start,
                                               int unsigned size, int unsigned bs,
                                               int unsigned amt);
    int unsigned lo;
    int unsigned hi;
    int unsigned half;
    logic [1:0]  res;
    lo = 2 * idx + 1;
    hi = lo + 1;
    half = size / 2;
    if (idx >= NODE_COUNT || tree_q[idx] == NS_ABSENT) return ST_NO_MATCH;
    if (start == bs && size == amt) begin
      if (tree_q[idx] == NS_ALLOC) begin
        tree_q[idx] = NS_FREE;
        return ST_FREED;
      end
      return ST_NO_MATCH;
    end
    if (tree_q[idx] != NS_SPLIT || hi >= NODE_COUNT) return ST_NO_MATCH;
    if (bs < start + half) res = release_block(lo, start, half, bs, amt);
    else res = release_block(hi, start + half, half, bs, amt);
    if (res == ST_FREED && tree_q[lo] == NS_FREE && tree_q[hi] == NS_FREE) begin
      tree_q[lo] = NS_ABSENT;
      tree_q[hi] = NS_ABSENT;
      tree_q[idx] = NS_FREE;
    end
    return res;
  endfunction

  // Predict the outcome of one request and queue it for the driver.
  task automatic queue_request(logic op, int unsigned amt, int unsigned bs);
    request_t    r;
    int unsigned where;
    int unsigned want;
    int unsigned blk;
    r.op = op;
    r.amount = amt[AMT_W-1:0];
    r.block_start = bs[ADDR_W-1:0];
    want = (r.amount == 0) ? 1 : r.amount;
    if (op == OP_ALLOC) begin
      if (carve_block(0, 0, TOTAL_UNITS, want, where)) begin
        r.exp_status = ST_ALLOCATED;
        r.exp_addr = where[ADDR_W-1:0];
        blk = TOTAL_UNITS;
        while (blk / 2 >= want && blk >= 2) blk = blk / 2;
        live_blocks.push_back('{where, blk});
      end else begin
        r.exp_status = ST_NO_SPACE;
        r.exp_addr = '0;
      end
    end else begin
      r.exp_status = release_block(0, 0, TOTAL_UNITS, r.block_start, r.amount);
      r.exp_addr = '0;
      if (r.exp_status == ST_FREED) begin
        foreach (live_blocks[k]) begin
          if (live_blocks[k].start == r.block_start && live_blocks[k].size == r.amount) begin
            live_blocks.delete(k);
            break;
          end
        end
      end
    end
    req_pending.push_back(r);
  endtask

  // Mostly well-formed traffic: allocations and frees of live blocks, plus noise.
  task automatic queue_random(int unsigned count);
    int unsigned roll;
    int unsigned k;
    int unsigned amt;
    block_t      b;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 55 || (live_blocks.size() == 0 && roll < 90)) begin
        roll = $urandom_range(99);
        if (roll < 70) amt = $urandom_range(1, 64);
        else if (roll < 92) amt = $urandom_range(1, 1024);
        else if (roll < 97) amt = $urandom_range(1025, 2047);
        else amt = 0;
        queue_request(OP_ALLOC, amt, $urandom_range(1023));
      end else if (roll < 90) begin
        k = $urandom_range(live_blocks.size() - 1);
        b = live_blocks[k];
        queue_request(OP_FREE, b.size, b.start);
      end else if (roll < 95 && live_blocks.size() > 0) begin
        // Free a live block with a size one step off.
        k = $urandom_range(live_blocks.size() - 1);
        b = live_blocks[k];
        amt = ($urandom_range(1) != 0) ? b.size * 2 : b.size / 2;
        queue_request(OP_FREE, amt, b.start);
      end else begin
        queue_request($urandom_range(1), $urandom_range(2047), $urandom_range(1023));
      end
    end
  endtask

  // Wait until the block has answered every request handed to it.
  task automatic wait_drained();
    while (req_pending.size() != 0 || grant_expected.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus sequence.
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    hold_req = 1'b0;
    in_transfer = 1'b0;
    fail_count = 0;
    quiet_cycles = 0;
    foreach (tree_q[i]) tree_q[i] = NS_ABSENT;
    tree_q[0] = NS_FREE;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners: whole pool, zero and oversized sizes, bad frees.
    queue_request(OP_ALLOC, 1024, 0);
    queue_request(OP_ALLOC, 1, 0);
    queue_request(OP_FREE, 1024, 0);
    queue_request(OP_FREE, 1024, 0);
    queue_request(OP_ALLOC, 0, 1023);
    queue_request(OP_ALLOC, 1, 0);
    queue_request(OP_FREE, 2, 0);
    queue_request(OP_FREE, 1, 0);
    queue_request(OP_FREE, 1, 0);
    queue_request(OP_FREE, 512, 0);
    queue_request(OP_ALLOC, 2047, 0);
    queue_request(OP_ALLOC, 1025, 0);
    queue_request(OP_FREE, 2047, 1023);
    queue_request(OP_FREE, 1, 1023);
    queue_request(OP_ALLOC, 512, 0);
    queue_request(OP_ALLOC, 300, 0);
    queue_request(OP_ALLOC, 3, 0);
    queue_request(OP_FREE, 512, 512);
    queue_request(OP_FREE, 1, 2);
    queue_request(OP_FREE, 4, 0);
    queue_request(OP_FREE, 1, 0);
    queue_request(OP_FREE, 512, 512);
    queue_request(OP_FREE, 512, 0);
    queue_request(OP_ALLOC, 1024, 0);
    queue_request(OP_FREE, 1024, 0);
    wait_drained();

    // No idling, with one long receiver hold-off while the sender keeps going.
    queue_random(420);
    hold_req = 1'b1;
    wait_drained();

    send_idle_pct = 46;
    recv_stall_pct = 0;
    queue_random(420);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 46;
    queue_random(420);
    wait_drained();

    send_idle_pct = 33;
    recv_stall_pct = 33;
    queue_random(420);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Request driver: moves the head of the pending queue onto the input channel.
  always @(negedge clk_i) begin
    logic offer;
    if (rst_ni) begin
      if (in_transfer) begin
        grant_expected.push_back('{req_pending[0].exp_addr, req_pending[0].exp_status});
        req_pending.pop_front();
      end
      offer = s_axis_tvalid && !in_transfer;
      if (!offer && req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offer = 1'b1;
      end
      if (req_pending.size() == 0) offer = 1'b0;
      if (req_pending.size() != 0) begin
        s_axis_tdata <= {3'b000, req_pending[0].block_start, req_pending[0].amount};
        s_axis_tuser <= req_pending[0].op;
      end
      s_axis_tvalid <= offer;
    end
  end

  // Result receiver: random stalls and one long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    grant_t g;
    in_transfer = s_axis_tvalid && s_axis_tready;
    if (m_axis_tvalid && m_axis_tready) begin
      if (grant_expected.size() == 0) begin
        $error("result transfer with nothing expected: start_address %0d status %0d",
               m_axis_tdata[ADDR_W-1:0], m_axis_tuser);
        fail_count++;
      end else begin
        g = grant_expected.pop_front();
        if (m_axis_tdata[ADDR_W-1:0] !== g.addr) begin
          $error("start_address: expected %0d, got %0d", g.addr, m_axis_tdata[ADDR_W-1:0]);
          fail_count++;
        end
        if (m_axis_tuser !== g.status) begin
          $error("status: expected %0d, got %0d", g.status, m_axis_tuser);
          fail_count++;
        end
      end
    end
    if (!rst_ni || in_transfer || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

endmodule
